FILE: src/kv_record_stream_parser_top_macros.svh
// assertion macros for the kv record stream parser checker
// no dependencies
`ifndef KV_RECORD_STREAM_PARSER_TOP_MACROS_SVH
`define KV_RECORD_STREAM_PARSER_TOP_MACROS_SVH
// assert that an antecedent implies a consequent in the next cycle
`define KV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// assert that an antecedent implies a consequent in the same cycle
`define KV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

FILE: src/kvp_pkg.sv
// shared types and constants for the kv record stream parser
// no dependencies
package kvp_pkg;
    localparam logic [2:0] ROLE_LEN = 3'd0;
    localparam logic [2:0] ROLE_HDR = 3'd1;
    localparam logic [2:0] ROLE_KEY = 3'd2;
    localparam logic [2:0] ROLE_VAL = 3'd3;
    localparam logic [2:0] ROLE_IGN = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_LEN = 3'd1;
    localparam logic [2:0] ST_KEY_LONG = 3'd2;
    localparam logic [2:0] ST_KEY_FIT = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;

    localparam logic [1:0] REG_MAX_KEY = 2'd0;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  role;
        logic [15:0] record_index;
        logic        key_textual;
        logic [6:0]  key_length;
        logic [63:0] key_numeric;
        logic [27:0] value_length;
        logic        record_end;
        logic        buffer_end;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;
endpackage

FILE: src/kvp_in_queue.sv
// two-entry queue between the input side and the parser core
// uses kvp_pkg
module kvp_in_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  kvp_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output kvp_pkg::item_t out_item
);
    import kvp_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_item;
    end
endmodule

FILE: src/kvp_core.sv
// parser state machine: consumes one byte per cycle unless its output is stalled, registers one result
// uses kvp_pkg
module kvp_core #(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int NUMBER_KEY_BYTES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [6:0]       max_key_length,
    input  logic             in_valid,
    output logic             in_ready,
    input  kvp_pkg::item_t   in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output kvp_pkg::result_t out_result
);
    import kvp_pkg::*;

    localparam int LBC_W = $clog2(MAX_LENGTH_BYTES + 2);
    localparam int KBS_W = $clog2(NUMBER_KEY_BYTES + 1);

    typedef enum logic [4:0] {
        PH_LEN = 5'b00001,
        PH_HDR = 5'b00010,
        PH_KEY = 5'b00100,
        PH_VAL = 5'b01000,
        PH_ERR = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [27:0] len_acc_reg, len_acc_next;
    logic [LBC_W-1:0] lbc_reg, lbc_next;
    logic [27:0] pay_rem_reg, pay_rem_next;
    logic [6:0]  key_rem_reg, key_rem_next;
    logic [KBS_W-1:0] kbs_reg, kbs_next;
    logic        kstr_reg, kstr_next;
    logic [6:0]  klen_reg, klen_next;
    logic [63:0] nkey_reg, nkey_next;
    logic [15:0] rec_cnt_reg, rec_cnt_next;
    logic [2:0]  err_reg, err_next;
    logic [27:0] vlen_reg, vlen_next;
    logic        ovalid_reg;
    result_t     res_reg, res_next;
    logic        take;
    logic [7:0]  b;
    logic [2:0]  role;
    logic        rec_end;

    assign in_ready   = !ovalid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = ovalid_reg;
    assign out_result = res_reg;
    assign b = in_item.data_byte;

    always_comb begin
        phase_next = phase_reg;
        len_acc_next = len_acc_reg;
        lbc_next = lbc_reg;
        pay_rem_next = pay_rem_reg;
        key_rem_next = key_rem_reg;
        kbs_next = kbs_reg;
        kstr_next = kstr_reg;
        klen_next = klen_reg;
        nkey_next = nkey_reg;
        rec_cnt_next = rec_cnt_reg;
        err_next = err_reg;
        vlen_next = vlen_reg;
        role = ROLE_IGN;
        rec_end = 1'b0;
        case (phase_reg)
            PH_LEN: begin
                role = ROLE_LEN;
                if (lbc_reg == '0) begin
                    len_acc_next = '0;
                    kstr_next = 1'b0;
                    klen_next = '0;
                    nkey_next = '0;
                    vlen_next = '0;
                end
                lbc_next = lbc_reg + 1'b1;
                if (lbc_next > LBC_W'(MAX_LENGTH_BYTES)) begin
                    err_next = ST_BAD_LEN;
                    phase_next = PH_ERR;
                end else begin
                    len_acc_next = {len_acc_next[20:0], b[6:0]};
                    if (!b[7]) begin
                        lbc_next = '0;
                        if (len_acc_next == '0) begin
                            err_next = ST_BAD_LEN;
                            phase_next = PH_ERR;
                        end else begin
                            pay_rem_next = len_acc_next;
                            phase_next = PH_HDR;
                        end
                    end
                end
            end
            PH_HDR: begin
                role = ROLE_HDR;
                kstr_next = b[7];
                klen_next = b[6:0];
                if (b[6:0] > max_key_length) begin
                    err_next = ST_KEY_LONG;
                    phase_next = PH_ERR;
                end else if ({21'd0, b[6:0]} + 28'd1 > pay_rem_reg
                             || pay_rem_reg == '0) begin
                    err_next = ST_KEY_FIT;
                    phase_next = PH_ERR;
                end else begin
                    pay_rem_next = pay_rem_reg - 28'd1;
                    vlen_next = pay_rem_next - {21'd0, b[6:0]};
                    key_rem_next = b[6:0];
                    kbs_next = '0;
                    if (b[6:0] != '0) phase_next = PH_KEY;
                    else if (pay_rem_next != '0) phase_next = PH_VAL;
                    else rec_end = 1'b1;
                end
            end
            PH_KEY: begin
                role = ROLE_KEY;
                if (!kstr_reg && kbs_reg < KBS_W'(NUMBER_KEY_BYTES)) begin
                    nkey_next = {nkey_reg[55:0], b};
                    kbs_next = kbs_reg + 1'b1;
                end
                key_rem_next = key_rem_reg - 7'd1;
                pay_rem_next = pay_rem_reg - 28'd1;
                if (key_rem_next == '0) begin
                    if (pay_rem_next != '0) phase_next = PH_VAL;
                    else rec_end = 1'b1;
                end
            end
            PH_VAL: begin
                role = ROLE_VAL;
                pay_rem_next = pay_rem_reg - 28'd1;
                if (pay_rem_next == '0) rec_end = 1'b1;
            end
            default: role = ROLE_IGN;
        endcase
        if (rec_end) begin
            phase_next = PH_LEN;
            lbc_next = '0;
            if (rec_cnt_reg != 16'hFFFF) rec_cnt_next = rec_cnt_reg + 16'd1;
        end
        if (in_item.last_byte && err_next == ST_OK
            && (phase_next != PH_LEN || lbc_next != '0)) begin
            err_next = ST_OVERRUN;
            phase_next = PH_ERR;
        end
        res_next.byte_out = b;
        res_next.role = role;
        res_next.record_index = rec_cnt_reg;
        res_next.key_textual = kstr_next;
        res_next.key_length = klen_next;
        res_next.key_numeric = nkey_next;
        res_next.value_length = vlen_next;
        res_next.record_end = rec_end;
        res_next.buffer_end = in_item.last_byte;
        res_next.status = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && in_item.last_byte)) begin
            phase_reg <= PH_LEN;
            len_acc_reg <= '0;
            lbc_reg <= '0;
            pay_rem_reg <= '0;
            key_rem_reg <= '0;
            kbs_reg <= '0;
            kstr_reg <= 1'b0;
            klen_reg <= '0;
            nkey_reg <= '0;
            rec_cnt_reg <= '0;
            err_reg <= ST_OK;
            vlen_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            len_acc_reg <= len_acc_next;
            lbc_reg <= lbc_next;
            pay_rem_reg <= pay_rem_next;
            key_rem_reg <= key_rem_next;
            kbs_reg <= kbs_next;
            kstr_reg <= kstr_next;
            klen_reg <= klen_next;
            nkey_reg <= nkey_next;
            rec_cnt_reg <= rec_cnt_next;
            err_reg <= err_next;
            vlen_reg <= vlen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (take) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) res_reg <= res_next;
    end
endmodule

FILE: src/kv_record_stream_parser_top.sv
// kv record stream parser: top level with apb register, input queue and core
// uses kvp_pkg, kvp_in_queue, kvp_core
//
// usage
// - input channel s_valid/s_ready carries one buffer byte per item
//   (s_data_byte, s_last_byte marks the final byte of the buffer)
// - result channel m_valid/m_ready gives one result item per input item,
//   in order: echo, byte role, record index, key fields, status
// - apb port holds max_key_length at address 0 (pready always high)
// - each item passes through the input queue and then the core's output
//   register; throughput is one item per cycle while m_ready does not
//   stall the core, set by the parser state update
// - a two-entry queue decouples the input side from the core; when the
//   receiver stalls, the core holds its result and the queue fills, then
//   s_ready drops
// - reset empties the queue, clears the output valid flag and all parse state;
//   max_key_length returns to 32
// - after the last buffer byte the parse state returns to reset
module kv_record_stream_parser_top #(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int NUMBER_KEY_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_out,
    output logic [2:0]  m_role,
    output logic [15:0] m_record_index,
    output logic        m_key_textual,
    output logic [6:0]  m_key_length,
    output logic [63:0] m_key_numeric,
    output logic [27:0] m_value_length,
    output logic        m_record_end,
    output logic        m_buffer_end,
    output logic [2:0]  m_status
);
    import kvp_pkg::*;

    logic [6:0] max_key_reg;
    item_t      s_item, q_item;
    logic       q_valid, q_ready;
    result_t    res;

    // config register, written in the apb access phase
    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_KEY) ? {25'd0, max_key_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_key_reg <= 7'd32;
        end else if (psel && penable && pwrite && paddr == REG_MAX_KEY) begin
            max_key_reg <= pwdata[6:0];
        end
    end

    assign s_item.data_byte = s_data_byte;
    assign s_item.last_byte = s_last_byte;

    // front: decoupling queue
    kvp_in_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back: parser core with registered result
    kvp_core #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .NUMBER_KEY_BYTES (NUMBER_KEY_BYTES)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_key_length (max_key_reg),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_item        (q_item),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_result     (res)
    );

    assign m_byte_out     = res.byte_out;
    assign m_role         = res.role;
    assign m_record_index = res.record_index;
    assign m_key_textual  = res.key_textual;
    assign m_key_length   = res.key_length;
    assign m_key_numeric  = res.key_numeric;
    assign m_value_length = res.value_length;
    assign m_record_end   = res.record_end;
    assign m_buffer_end   = res.buffer_end;
    assign m_status       = res.status;
endmodule

FILE: src/kvp_checker.sv
// port-level checker for the kv record stream parser, bound to the top
// uses kv_record_stream_parser_top_macros.svh and kvp_pkg
`include "kv_record_stream_parser_top_macros.svh"
module kvp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_role,
    input logic [15:0] m_record_index,
    input logic        m_record_end,
    input logic        m_buffer_end,
    input logic [2:0]  m_status
);
    import kvp_pkg::*;

    `KV_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_role), "result dropped while stalled")
    `KV_ASSERT_SAME(a_end_ok, aclk, aresetn, m_valid && m_record_end, m_role != ROLE_IGN && m_role != ROLE_LEN, "record end on bad role")
    `KV_ASSERT_SAME(a_ign_err, aclk, aresetn, m_valid && m_role == ROLE_IGN, m_status != ST_OK, "ignored item without error")
    `KV_ASSERT_NEXT(a_restart, aclk, aresetn, m_valid && m_ready && m_buffer_end, !m_valid || m_record_index == 16'd0, "index not cleared after buffer end")
endmodule

bind kv_record_stream_parser_top kvp_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_role         (m_role),
    .m_record_index (m_record_index),
    .m_record_end   (m_record_end),
    .m_buffer_end   (m_buffer_end),
    .m_status       (m_status)
);
